FILE: src/gete_pkg.sv
package gete_pkg;

  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned DIV_STEPS  = 4;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [31:0] DAY_BIAS   = 32'd865565;
  localparam logic [12:0] YEAR_BIAS  = 13'd400;

  typedef struct packed {
    logic zero;
    logic sat;
  } gete_flag_t;

  function automatic logic [8:0] doy_base(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: src/gps_event_timestamp_to_epoch_ns_core.sv
// gps event timestamp to epoch nanoseconds
// input channel: one beat carries an event's gps calendar fields, leap count,
// tick count since the last pulse and the raw tick period (bit 31 ignored)
// result channel: one beat per input beat, in order, with utc seconds since
// 1970 modulo 2^32, sub-second nanoseconds floor(count*1e9/period) saturated
// at 2^32-1 (zero for a zero period) and the combined 64-bit nanosecond total
// throughput one beat per cycle unless stalled (see below), set by
// an 11-stage pipeline whose long part is a restoring divider
// retiring 4 quotient bits per stage over 8 stages
// reset: synchronous active low rst_n empties the pipeline, no result is shown
// stall: while out_valid is high and out_ready low, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated
module gps_event_timestamp_to_epoch_ns_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_calendar_year,
  input  logic [7:0]  in_month_of_year,
  input  logic [7:0]  in_day_of_month,
  input  logic [7:0]  in_hour_of_day,
  input  logic [7:0]  in_minute_of_hour,
  input  logic [7:0]  in_second_of_minute,
  input  logic [15:0] in_leap_seconds,
  input  logic [31:0] in_counts_since_pulse,
  input  logic [31:0] in_counts_per_second_raw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_total_nanoseconds,
  output logic [31:0] out_whole_seconds,
  output logic [31:0] out_sub_second_ns
);

  logic        en;
  logic [10:1] v_r;
  logic        out_valid_r;

  // stage 1
  logic [61:0] prod_r;
  logic [30:0] per1_r;
  logic [12:0] y2_r;
  logic signed [10:0] doy_r;
  logic [31:0] secs1_r;
  // stage 2
  logic [31:0] days_r;
  logic [31:0] secs2_r;
  logic [30:0] rem0_r;
  logic [31:0] lo0_r;
  logic [30:0] den0_r;
  gete_pkg::gete_flag_t flag_r [2:10];
  // stage 3 and on
  logic [31:0] whole_r [3:10];
  logic [63:0] wns_r   [4:10];
  logic [31:0] q10;
  // outputs
  logic [63:0] tot_r;
  logic [31:0] ws_r;
  logic [31:0] ns_r;

  logic [7:0]  m1;
  logic [4:0]  ycar;
  logic [3:0]  mnorm;
  logic [3:0]  mp;
  logic [12:0] y2_nxt;
  logic signed [10:0] doy_nxt;
  logic [31:0] secs_nxt;
  logic [25:0] ymul;
  logic [12:0] q100;
  logic [31:0] days_nxt;
  logic [31:0] ns_nxt;
  logic [15:0] mq;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    m1   = in_month_of_year - 8'd1;
    mq   = 16'(m1) * 16'd171;
    if (in_month_of_year == 8'd0) begin
      ycar  = 5'd0;
      mnorm = 4'd11;
    end else begin
      ycar  = mq[15:11];
      mnorm = 4'(m1 - 8'(ycar) * 8'd12);
    end
    mp = (mnorm >= 4'd2) ? mnorm - 4'd2 : mnorm + 4'd10;
    y2_nxt = 13'(in_calendar_year) + gete_pkg::YEAR_BIAS + 13'(ycar)
           - 13'(in_month_of_year == 8'd0) - 13'(mnorm < 4'd2);
    doy_nxt = $signed({2'b00, gete_pkg::doy_base(mp)}) + $signed({3'b000, in_day_of_month})
            - 11'sd1;
    secs_nxt = 32'(in_hour_of_day) * 32'd3600 + 32'(in_minute_of_hour) * 32'd60
             + 32'(in_second_of_minute) - 32'(in_leap_seconds);
    ymul = 26'(y2_r) * 26'd5243;
    q100 = 13'(ymul >> 19);
    days_nxt = 32'(y2_r) * 32'd365 + 32'(y2_r >> 2) - 32'(q100) + 32'(q100 >> 2)
             + 32'(doy_r) - gete_pkg::DAY_BIAS;
    if (flag_r[10].zero) begin
      ns_nxt = 32'd0;
    end else if (flag_r[10].sat) begin
      ns_nxt = 32'hFFFF_FFFF;
    end else begin
      ns_nxt = q10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[9:1], in_valid};
      out_valid_r <= v_r[10];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 62'(in_counts_since_pulse) * 62'(gete_pkg::NS_PER_SEC);
      per1_r  <= in_counts_per_second_raw[30:0];
      y2_r    <= y2_nxt;
      doy_r   <= doy_nxt;
      secs1_r <= secs_nxt;

      days_r  <= days_nxt;
      secs2_r <= secs1_r;
      rem0_r  <= {1'b0, prod_r[61:32]};
      lo0_r   <= prod_r[31:0];
      den0_r  <= per1_r;
      flag_r[2].zero <= (per1_r == 31'd0);
      flag_r[2].sat  <= ({1'b0, prod_r[61:32]} >= per1_r);
      for (int i = 3; i <= 10; i++) flag_r[i] <= flag_r[i-1];

      whole_r[3] <= days_r * 32'd86400 + secs2_r;
      for (int i = 4; i <= 10; i++) whole_r[i] <= whole_r[i-1];
      wns_r[4] <= 64'(whole_r[3]) * 64'(gete_pkg::NS_PER_SEC);
      for (int i = 5; i <= 10; i++) wns_r[i] <= wns_r[i-1];

      tot_r <= wns_r[10] + 64'(ns_nxt);
      ws_r  <= whole_r[10];
      ns_r  <= ns_nxt;
    end
  end

  gete_div u_div (
    .clk   (clk),
    .en    (en),
    .rem_i (rem0_r[30:0]),
    .lo_i  (lo0_r),
    .den_i (den0_r),
    .q_o   (q10)
  );

  assign out_valid             = out_valid_r;
  assign out_total_nanoseconds = tot_r;
  assign out_whole_seconds     = ws_r;
  assign out_sub_second_ns     = ns_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(v_r))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && v_r == '0))
    else $error("pipeline not empty after reset");

  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[10]) |=> out_valid_r)
    else $error("last stage beat lost");

  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[10] && flag_r[10].zero) |=> (out_sub_second_ns == 32'd0))
    else $error("zero period gave nonzero ns");

endmodule

FILE: src/gete_div.sv
module gete_div (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] rem_i,
  input  logic [31:0] lo_i,
  input  logic [30:0] den_i,
  output logic [31:0] q_o
);

  localparam int unsigned NS = gete_pkg::DIV_STAGES;

  logic [30:0] rem_r [NS];
  logic [31:0] lo_r  [NS];
  logic [31:0] q_r   [NS];
  logic [30:0] den_r [NS];
  logic [30:0] rem_nxt [NS];
  logic [31:0] lo_nxt  [NS];
  logic [31:0] q_nxt   [NS];

  always_comb begin
    logic [30:0] r;
    logic [31:0] lo;
    logic [31:0] q;
    logic [30:0] d;
    logic [31:0] t;
    for (int s = 0; s < NS; s++) begin
      r  = (s == 0) ? rem_i : rem_r[(s == 0) ? 0 : s - 1];
      lo = (s == 0) ? lo_i  : lo_r[(s == 0) ? 0 : s - 1];
      q  = (s == 0) ? 32'd0 : q_r[(s == 0) ? 0 : s - 1];
      d  = (s == 0) ? den_i : den_r[(s == 0) ? 0 : s - 1];
      for (int k = 0; k < gete_pkg::DIV_STEPS; k++) begin
        t  = {r, lo[31]};
        lo = {lo[30:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t = t - {1'b0, d};
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
        r = t[30:0];
      end
      rem_nxt[s] = r;
      lo_nxt[s]  = lo;
      q_nxt[s]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_r[s] <= rem_nxt[s];
        lo_r[s]  <= lo_nxt[s];
        q_r[s]   <= q_nxt[s];
        den_r[s] <= (s == 0) ? den_i : den_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign q_o = q_r[NS-1];

endmodule
